FILE: src/bmq_pkg.sv
// Package for the bucketed multi-queue unit: sizes, field widths, status codes
// and the structures shared by the scan logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bmq_pkg;

  localparam int DIVISIONS = 100;
  localparam int CAPACITY  = 256;

  localparam int DIV_W = 7;
  localparam int SID_W = 24;
  localparam int TAG_W = 16;

  // Node pointer, link word (pointer plus a "none" flag) and division index.
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = PW + 1;
  localparam int DW = (DIVISIONS > 1) ? $clog2(DIVISIONS) : 1;

  // Occupancy scan is done in groups of eight divisions.
  localparam int GRP_BITS = 8;
  localparam int GROUPS   = (DIVISIONS + GRP_BITS - 1) / GRP_BITS;
  localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic          found;
    logic [DW-1:0] idx;
  } scan_res_t;

  typedef struct packed {
    status_t          status;
    logic [DIV_W-1:0] division;
    logic [SID_W-1:0] student_id;
    logic [TAG_W-1:0] name_tag;
    logic             done;
  } res_t;

endpackage

FILE: src/bmq_if.sv
// Valid/ready channel interfaces for the bucketed multi-queue unit: one for
// requests, one for results. Depends on bmq_pkg for the field widths.
`timescale 1ns / 1ps

interface bmq_in_if;
  import bmq_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [DIV_W-1:0] division;
  logic [SID_W-1:0] student_id;
  logic [TAG_W-1:0] name_tag;

  modport source (output valid, func, division, student_id, name_tag, input ready);
  modport sink   (input valid, func, division, student_id, name_tag, output ready);
endinterface

interface bmq_out_if;
  import bmq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [DIV_W-1:0] out_division;
  logic [SID_W-1:0] out_student_id;
  logic [TAG_W-1:0] out_name_tag;
  logic             division_done;

  modport source (output valid, status, out_division, out_student_id, out_name_tag,
                  division_done, input ready);
  modport sink   (input valid, status, out_division, out_student_id, out_name_tag,
                  division_done, output ready);
endinterface

FILE: src/bucketed_multi_queue_unit.sv
// Bucketed multi-queue unit: one FIFO per division over a shared linked node store.
// Depends on bmq_pkg, the channel interfaces in bmq_if, bmq_ram and bmq_scan.
`timescale 1ns / 1ps

// A user of this block sends enqueue and dequeue requests and gets exactly one
// result for each, in order. An enqueue appends a record to its division's
// FIFO; a dequeue returns the oldest record of the lowest-numbered non-empty
// division and flags when that record was the last of its division. Requests
// are handled one at a time. An accepted enqueue reads the pointer and link
// memories, then writes them back; one refused for range or a full store goes
// straight to its result. A dequeue passes the occupancy bits through a
// registered group stage, reads the pointer memory, then the node memories,
// then updates pointers and the recycle list; on an empty store it stops
// after the group stage. The next request is taken in the same cycle as the
// result enters the output register, so a result waiting downstream costs
// nothing until a second result is ready behind it. No clearing pass is needed
// after reset: only control flops, e.g. occupancy bits and counters, are reset.
module bucketed_multi_queue_unit (
  input logic      clk,
  input logic      rst_n,
  bmq_in_if.sink   in_ch,
  bmq_out_if.source out_ch
);
  import bmq_pkg::*;

  localparam logic [PW:0]    CNT_FULL  = (PW + 1)'(CAPACITY);
  localparam logic [DIV_W:0] DIV_LIMIT = (DIV_W + 1)'(DIVISIONS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PICK = 6'b000010,
    S_ENQ  = 6'b000100,
    S_DQ1  = 6'b001000,
    S_DQ2  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Bookkeeping held in flip-flops.
  logic [DIVISIONS-1:0] mask_r, mask_nxt;
  logic [PW:0]          fresh_r, fresh_nxt;
  logic [PW:0]          count_r, count_nxt;
  logic                 rec_valid_r, rec_valid_nxt;
  logic [PW-1:0]        rec_head_r, rec_head_nxt;

  // Request and intermediate payload.
  logic [DW-1:0]    div_r, div_nxt;
  logic [SID_W-1:0] sid_r, sid_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  res_t             res_r, res_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  logic slot_free;
  logic in_ready;
  logic accept;
  logic range_bad;
  logic [DW-1:0] acc_div;
  logic [PW-1:0] new_node;

  // Memory ports.
  logic                  ptr_we, ptr_re;
  logic [DW-1:0]         ptr_waddr, ptr_raddr;
  logic [2*PW-1:0]       ptr_wdata, ptr_rdata;
  logic                  link_we, link_re;
  logic [PW-1:0]         link_waddr, link_raddr;
  logic [LW-1:0]         link_wdata, link_rdata;
  logic                  data_we, data_re;
  logic [PW-1:0]         data_waddr, data_raddr;
  logic [SID_W+TAG_W-1:0] data_wdata, data_rdata;

  scan_res_t scan;

  // Head and tail pointer of each division, packed as {head, tail}.
  bmq_ram #(.WIDTH(2 * PW), .DEPTH(DIVISIONS)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  // Next-node links; the top bit marks the end of the recycle list.
  bmq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // Record payload of each node, packed as {student id, name tag}.
  bmq_ram #(.WIDTH(SID_W + TAG_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (data_re),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  bmq_scan u_scan (
    .clk  (clk),
    .mask (mask_r),
    .res  (scan)
  );

  // The output register can take a result when it is empty or being emptied.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_RESP) && slot_free);
  assign accept    = in_ch.valid && in_ready;

  assign range_bad = (in_ch.division == '0) || ({1'b0, in_ch.division} > DIV_LIMIT);
  assign acc_div   = DW'(in_ch.division - DIV_W'(1));

  // A recycled node is reused before a fresh one is taken.
  assign new_node  = rec_valid_r ? rec_head_r : fresh_r[PW-1:0];

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    fresh_nxt     = fresh_r;
    count_nxt     = count_r;
    rec_valid_nxt = rec_valid_r;
    rec_head_nxt  = rec_head_r;
    div_nxt       = div_r;
    sid_nxt       = sid_r;
    tag_nxt       = tag_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    ptr_we     = 1'b0;
    ptr_waddr  = div_r;
    ptr_wdata  = {head_r, tail_r};
    ptr_re     = 1'b0;
    ptr_raddr  = acc_div;
    link_we    = 1'b0;
    link_waddr = head_r;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = rec_head_r;
    data_we    = 1'b0;
    data_waddr = new_node;
    data_wdata = {sid_r, tag_r};
    data_re    = 1'b0;
    data_raddr = ptr_rdata[2*PW-1:PW];

    // Output register drains independently of the request side.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      S_PICK: begin
        if (!scan.found) begin
          res_nxt        = '0;
          res_nxt.status = ST_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          div_nxt   = scan.idx;
          ptr_re    = 1'b1;
          ptr_raddr = scan.idx;
          state_nxt = S_DQ1;
        end
      end
      S_ENQ: begin
        // Append the new node behind the current tail, or start the list.
        data_we   = 1'b1;
        ptr_we    = 1'b1;
        ptr_waddr = div_r;
        if (mask_r[div_r]) begin
          ptr_wdata  = {ptr_rdata[2*PW-1:PW], new_node};
          link_we    = 1'b1;
          link_waddr = ptr_rdata[PW-1:0];
          link_wdata = {1'b0, new_node};
        end else begin
          ptr_wdata = {new_node, new_node};
        end
        mask_nxt[div_r] = 1'b1;
        if (rec_valid_r) begin
          rec_head_nxt  = link_rdata[PW-1:0];
          rec_valid_nxt = !link_rdata[PW];
        end else begin
          fresh_nxt = fresh_r + (PW + 1)'(1);
        end
        count_nxt      = count_r + (PW + 1)'(1);
        res_nxt        = '0;
        res_nxt.status = ST_OK;
        state_nxt      = S_RESP;
      end
      S_DQ1: begin
        head_nxt   = ptr_rdata[2*PW-1:PW];
        tail_nxt   = ptr_rdata[PW-1:0];
        data_re    = 1'b1;
        data_raddr = ptr_rdata[2*PW-1:PW];
        link_re    = 1'b1;
        link_raddr = ptr_rdata[2*PW-1:PW];
        state_nxt  = S_DQ2;
      end
      S_DQ2: begin
        res_nxt.status     = ST_OK;
        res_nxt.division   = DIV_W'(div_r) + DIV_W'(1);
        res_nxt.student_id = data_rdata[SID_W+TAG_W-1:TAG_W];
        res_nxt.name_tag   = data_rdata[TAG_W-1:0];
        res_nxt.done       = (head_r == tail_r);
        if (head_r == tail_r) begin
          mask_nxt[div_r] = 1'b0;
        end else begin
          ptr_we    = 1'b1;
          ptr_waddr = div_r;
          ptr_wdata = {link_rdata[PW-1:0], tail_r};
        end
        // The freed node goes to the front of the recycle list.
        link_we       = 1'b1;
        link_waddr    = head_r;
        link_wdata    = rec_valid_r ? {1'b0, rec_head_r} : {1'b1, PW'(0)};
        rec_head_nxt  = head_r;
        rec_valid_nxt = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - (PW + 1)'(1);
        end
        state_nxt = S_RESP;
      end
      S_IDLE: begin
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new request is taken in idle, or as the previous result goes out.
    if (accept) begin
      div_nxt = acc_div;
      sid_nxt = in_ch.student_id;
      tag_nxt = in_ch.name_tag;
      res_nxt = '0;
      if (in_ch.func == FN_DEQ) begin
        state_nxt = S_PICK;
      end else if (range_bad) begin
        res_nxt.status = ST_RANGE;
        state_nxt      = S_RESP;
      end else if (count_r >= CNT_FULL) begin
        res_nxt.status = ST_FULL;
        state_nxt      = S_RESP;
      end else begin
        ptr_re     = 1'b1;
        ptr_raddr  = acc_div;
        link_re    = rec_valid_r;
        link_raddr = rec_head_r;
        state_nxt  = S_ENQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      fresh_r     <= '0;
      count_r     <= '0;
      rec_valid_r <= 1'b0;
      rec_head_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      rec_valid_r <= rec_valid_nxt;
      rec_head_r  <= rec_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    sid_r     <= sid_nxt;
    tag_r     <= tag_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.out_division   = out_res_r.division;
  assign out_ch.out_student_id = out_res_r.student_id;
  assign out_ch.out_name_tag   = out_res_r.name_tag;
  assign out_ch.division_done  = out_res_r.done;

  // The record count never passes the store size.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("stored record count above capacity");

  // Fresh nodes are never handed out beyond the store.
  a_fresh_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CNT_FULL)
    else $error("fresh node counter above capacity");

  // An enqueue only writes back when there was room for it at accept time.
  a_enq_room : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ENQ |-> count_r < CNT_FULL)
    else $error("enqueue write-back into a full store");

  // The division being dequeued is still marked as holding records.
  a_dq_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DQ2 |-> mask_r[div_r])
    else $error("dequeue from a division marked empty");

  // With no records stored, no division may be marked occupied.
  a_empty_mask : assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> mask_r == '0)
    else $error("occupancy bits set with an empty store");

endmodule

FILE: src/bmq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bmq_scan.sv
// Lowest non-empty division finder: a registered per-group stage followed by
// a priority pick across the groups. Depends on bmq_pkg.
`timescale 1ns / 1ps

module bmq_scan (
  input  logic                          clk,
  input  logic [bmq_pkg::DIVISIONS-1:0] mask,
  output bmq_pkg::scan_res_t            res
);
  import bmq_pkg::*;

  localparam int PAD_W = GROUPS * GRP_BITS;
  localparam int IW    = GW + 3;

  logic [PAD_W-1:0] pad;
  logic [GROUPS-1:0] grp_any_nxt, grp_any_r;
  logic [2:0]        grp_first_nxt [GROUPS];
  logic [2:0]        grp_first_r   [GROUPS];
  logic [IW-1:0]     idx_full;

  assign pad = PAD_W'(mask);

  // Per group: any bit set, and the position of the lowest set bit.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_nxt[g]   = |pad[g*GRP_BITS +: GRP_BITS];
      grp_first_nxt[g] = 3'd0;
      for (int b = GRP_BITS - 1; b >= 0; b--) begin
        if (pad[g*GRP_BITS + b]) begin
          grp_first_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r   <= grp_any_nxt;
    grp_first_r <= grp_first_nxt;
  end

  always_comb begin
    idx_full  = '0;
    res.found = |grp_any_r;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        idx_full = {GW'(g), grp_first_r[g]};
      end
    end
    res.idx = idx_full[DW-1:0];
  end

endmodule
